[hw/rtl/midpoint_ellipse_rasterizer_macros.svh]
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Shared concurrent assertion forms used by the rasterizer RTL.
// ---------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MER_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MER_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/mer_pkg.sv]
// ---------------------------------------------------------------------------
// mer_pkg
// Widths, codes and controller/datapath interface types of the rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 12;
    localparam int CFG_BITS    = 12;
    localparam int PIX_BITS    = 14;

    localparam int X_BITS   = RADIUS_BITS + 1;      // walk x, unsigned
    localparam int Y_BITS   = RADIUS_BITS + 2;      // walk y, signed (reaches -1)
    localparam int T_BITS   = X_BITS + 1;           // 2x+1
    localparam int SQ_BITS  = 2 * RADIUS_BITS;      // squared radii
    localparam int D_BITS   = 3 * RADIUS_BITS + 3;  // step_dx / step_dy, signed
    localparam int DEC_BITS = 4 * RADIUS_BITS + 8;  // 4x scaled decision, signed
    localparam int MA_BITS  = 3 * RADIUS_BITS + 2;  // multiplier operand a
    localparam int MB_BITS  = 2 * RADIUS_BITS + 2;  // multiplier operand b
    localparam int P_BITS   = MA_BITS + MB_BITS;
    localparam int CALC_BITS = ((COORD_BITS > Y_BITS) ? COORD_BITS : Y_BITS) + PIX_BITS;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_SCREEN_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT     = 2'd1;
    localparam logic [CFG_BITS-1:0] HALF_SCREEN_WIDTH_RESET = 12'd960;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET     = 12'd1080;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // quadrant of an emitted point: bit 1 mirrors x, bit 0 mirrors y
    localparam logic [1:0] QUAD_FIRST = 2'd0;
    localparam logic [1:0] QUAD_LAST  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RX_SQ,
        ST_RY_SQ,
        ST_DY_MUL,
        ST_DY_WB,
        ST_CHECK,
        ST_R2_T1,
        ST_R2_T2,
        ST_R2_Y1,
        ST_R2_Y2,
        ST_R2_XY,
        ST_R2_WB,
        ST_ADV_MOVE,
        ST_ADV_DEC,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RXSQ_RY,
        MUL_RYSQ_T,
        MUL_PROD_T,
        MUL_YM1_YM1,
        MUL_RXSQ_PROD,
        MUL_RXSQ_RYSQ
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_RX_SQ,
        WB_RY_SQ,
        WB_START,
        WB_DEC_SET,
        WB_DEC_ADD,
        WB_DEC_SUB
    } wb_sel_t;

    typedef struct packed {
        logic       load_start;
        logic       adv_move;
        logic       adv_dec;
        logic       load_out;
        logic [1:0] quad;
        mul_sel_t   mul_sel;
        wb_sel_t    wb_sel;
    } mer_cmd_t;

    typedef struct packed {
        logic active;
        logic region_two;
        logic dx_ge_dy;
        logic out_free;
    } mer_sts_t;

endpackage

`default_nettype wire

[hw/rtl/mer_ctrl.sv]
// ---------------------------------------------------------------------------
// mer_ctrl
// Sequencer: input handshake, multiply schedule, advance and point emission.
// ---------------------------------------------------------------------------
`default_nettype none
`include "midpoint_ellipse_rasterizer_macros.svh"

module mer_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              operation,
    output logic                   in_stall,
    input  wire mer_pkg::mer_sts_t sts,
    output mer_pkg::mer_cmd_t      cmd
);

    mer_pkg::state_t state_reg;
    mer_pkg::state_t state_next;
    logic [1:0]      quad_reg;
    logic [1:0]      quad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mer_pkg::ST_IDLE;
            quad_reg  <= mer_pkg::QUAD_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            quad_reg  <= quad_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        quad_next      = quad_reg;
        in_stall       = (state_reg != mer_pkg::ST_IDLE);
        cmd.load_start = 1'b0;
        cmd.adv_move   = 1'b0;
        cmd.adv_dec    = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.quad       = quad_reg;
        cmd.mul_sel    = mer_pkg::MUL_NONE;
        cmd.wb_sel     = mer_pkg::WB_NONE;

        unique case (state_reg)
            mer_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == mer_pkg::OP_START)
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = mer_pkg::ST_RX_SQ;
                    end
                    else if (sts.active)
                    begin
                        state_next = mer_pkg::ST_ADV_MOVE;
                    end
                end
            end
            mer_pkg::ST_RX_SQ:
            begin
                cmd.mul_sel = mer_pkg::MUL_RX_RX;
                state_next  = mer_pkg::ST_RY_SQ;
            end
            mer_pkg::ST_RY_SQ:
            begin
                cmd.wb_sel  = mer_pkg::WB_RX_SQ;
                cmd.mul_sel = mer_pkg::MUL_RY_RY;
                state_next  = mer_pkg::ST_DY_MUL;
            end
            mer_pkg::ST_DY_MUL:
            begin
                cmd.wb_sel  = mer_pkg::WB_RY_SQ;
                cmd.mul_sel = mer_pkg::MUL_RXSQ_RY;
                state_next  = mer_pkg::ST_DY_WB;
            end
            mer_pkg::ST_DY_WB:
            begin
                cmd.wb_sel = mer_pkg::WB_START;
                state_next = mer_pkg::ST_CHECK;
            end
            mer_pkg::ST_CHECK:
            begin
                if (!sts.region_two && sts.dx_ge_dy)
                    state_next = mer_pkg::ST_R2_T1;
                else
                    state_next = mer_pkg::ST_IDLE;
            end
            // region 2 setup: ry^2*t*t + 4*rx^2*(y-1)^2 - 4*rx^2*ry^2
            mer_pkg::ST_R2_T1:
            begin
                cmd.mul_sel = mer_pkg::MUL_RYSQ_T;
                state_next  = mer_pkg::ST_R2_T2;
            end
            mer_pkg::ST_R2_T2:
            begin
                cmd.mul_sel = mer_pkg::MUL_PROD_T;
                state_next  = mer_pkg::ST_R2_Y1;
            end
            mer_pkg::ST_R2_Y1:
            begin
                cmd.wb_sel  = mer_pkg::WB_DEC_SET;
                cmd.mul_sel = mer_pkg::MUL_YM1_YM1;
                state_next  = mer_pkg::ST_R2_Y2;
            end
            mer_pkg::ST_R2_Y2:
            begin
                cmd.mul_sel = mer_pkg::MUL_RXSQ_PROD;
                state_next  = mer_pkg::ST_R2_XY;
            end
            mer_pkg::ST_R2_XY:
            begin
                cmd.wb_sel  = mer_pkg::WB_DEC_ADD;
                cmd.mul_sel = mer_pkg::MUL_RXSQ_RYSQ;
                state_next  = mer_pkg::ST_R2_WB;
            end
            mer_pkg::ST_R2_WB:
            begin
                cmd.wb_sel = mer_pkg::WB_DEC_SUB;
                state_next = mer_pkg::ST_IDLE;
            end
            mer_pkg::ST_ADV_MOVE:
            begin
                cmd.adv_move = 1'b1;
                state_next   = mer_pkg::ST_ADV_DEC;
            end
            mer_pkg::ST_ADV_DEC:
            begin
                cmd.adv_dec = 1'b1;
                quad_next   = mer_pkg::QUAD_FIRST;
                state_next  = mer_pkg::ST_EMIT;
            end
            mer_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    quad_next    = quad_reg + 2'd1;
                    if (quad_reg == mer_pkg::QUAD_LAST)
                        state_next = mer_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase
    end

    `MER_ASSERT_NEXT(a_step_starts_move, clk, rst_n,
        in_valid && !in_stall && operation == mer_pkg::OP_STEP && sts.active,
        state_reg == mer_pkg::ST_ADV_MOVE)
    `MER_ASSERT_NEXT(a_group_ends_in_check, clk, rst_n,
        cmd.load_out && cmd.quad == mer_pkg::QUAD_LAST,
        state_reg == mer_pkg::ST_CHECK)
    `MER_ASSERT_NEXT(a_setup_sets_region, clk, rst_n,
        state_reg == mer_pkg::ST_R2_WB, sts.region_two)
    `MER_ASSERT_NEXT(a_region_two_no_resetup, clk, rst_n,
        state_reg == mer_pkg::ST_CHECK && sts.region_two,
        state_reg == mer_pkg::ST_IDLE)

endmodule

`default_nettype wire

[hw/rtl/mer_datapath.sv]
// ---------------------------------------------------------------------------
// mer_datapath
// Walk state, shared multiplier, decision update and point output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mer_datapath
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic        [mer_pkg::RADIUS_BITS-1:0] radius_x,
    input  wire logic        [mer_pkg::RADIUS_BITS-1:0] radius_y,
    input  wire logic signed [mer_pkg::COORD_BITS-1:0]  center_x,
    input  wire logic signed [mer_pkg::COORD_BITS-1:0]  center_y,
    input  wire logic        [mer_pkg::CFG_BITS-1:0]    half_screen_width,
    input  wire logic        [mer_pkg::CFG_BITS-1:0]    screen_height,
    input  wire logic                                  out_stall,
    output logic                                       out_valid,
    output logic signed      [mer_pkg::PIX_BITS-1:0]    pixel_x,
    output logic signed      [mer_pkg::PIX_BITS-1:0]    pixel_y,
    output logic                                       done_res,
    output logic                                       last,
    input  wire mer_pkg::mer_cmd_t                     cmd,
    output mer_pkg::mer_sts_t                          sts
);

    localparam int R   = mer_pkg::RADIUS_BITS;
    localparam int XB  = mer_pkg::X_BITS;
    localparam int YB  = mer_pkg::Y_BITS;
    localparam int TB  = mer_pkg::T_BITS;
    localparam int SQ  = mer_pkg::SQ_BITS;
    localparam int DB  = mer_pkg::D_BITS;
    localparam int DEC = mer_pkg::DEC_BITS;
    localparam int MA  = mer_pkg::MA_BITS;
    localparam int MB  = mer_pkg::MB_BITS;
    localparam int PB  = mer_pkg::P_BITS;
    localparam int CB  = mer_pkg::CALC_BITS;
    localparam int PIX = mer_pkg::PIX_BITS;
    localparam int CO  = mer_pkg::COORD_BITS;

    // control state
    logic region_two_reg, region_two_next;
    logic active_reg,     active_next;
    logic out_valid_reg,  out_valid_next;

    // walk state and operands
    logic [R-1:0]   rx_hold_reg, rx_hold_next;
    logic [XB-1:0]  cur_x_reg,   cur_x_next;
    logic [YB-1:0]  cur_y_reg,   cur_y_next;
    logic [DB-1:0]  step_dx_reg, step_dx_next;
    logic [DB-1:0]  step_dy_reg, step_dy_next;
    logic [DEC-1:0] decision_reg, decision_next;
    logic [SQ-1:0]  rx_sq_reg,   rx_sq_next;
    logic [SQ-1:0]  ry_sq_reg,   ry_sq_next;
    logic [CO-1:0]  held_cx_reg, held_cx_next;
    logic [CO-1:0]  held_cy_reg, held_cy_next;
    logic [PB-1:0]  prod_reg,    prod_next;
    logic [XB-1:0]  x0_reg,      x0_next;
    logic [YB-1:0]  y0_reg,      y0_next;
    logic           diag_reg,    diag_next;
    logic           done_reg,    done_next;

    // output register
    logic [PIX-1:0] pixel_x_reg, pixel_x_next;
    logic [PIX-1:0] pixel_y_reg, pixel_y_next;
    logic           done_res_reg, done_res_next;
    logic           last_reg,     last_next;

    // combinational helpers
    logic [TB-1:0]  t_val;
    logic [YB:0]    ym1;
    logic [YB:0]    ym1_mag;
    logic [MA-1:0]  mul_a;
    logic [MB-1:0]  mul_b;
    logic [DEC-1:0] prod_dec;
    logic [DEC-1:0] term;
    logic           dec_neg;
    logic           dec_zero;
    logic           move_x;
    logic           move_y;
    logic           use_dx;
    logic           use_dy;
    logic [CB-1:0]  sx;
    logic [CB-1:0]  sy;
    logic [CB-1:0]  px;
    logic [CB-1:0]  py;

    always_comb
    begin
        t_val    = {cur_x_reg, 1'b1};
        ym1      = {cur_y_reg[YB-1], cur_y_reg} - (YB+1)'(1);
        ym1_mag  = ym1[YB] ? ((YB+1)'(0) - ym1) : ym1;
        prod_dec = DEC'(prod_reg);
        dec_neg  = decision_reg[DEC-1];
        dec_zero = (decision_reg == '0);
        // region 1: x always moves, y when decision >= 0
        // region 2: y always moves, x when decision <= 0
        move_x   = !region_two_reg || dec_neg || dec_zero;
        move_y   = region_two_reg || !dec_neg;
        use_dx   = !region_two_reg || diag_reg;
        use_dy   = region_two_reg || diag_reg;
        term     = (use_dx ? DEC'($signed(step_dx_reg)) : '0)
                 - (use_dy ? DEC'($signed(step_dy_reg)) : '0)
                 + (region_two_reg ? DEC'(rx_sq_reg) : DEC'(ry_sq_reg));

        sx = cmd.quad[1] ? (CB'(0) - CB'(x0_reg)) : CB'(x0_reg);
        sy = cmd.quad[0] ? (CB'(0) - CB'($signed(y0_reg))) : CB'($signed(y0_reg));
        px = CB'(half_screen_width) + CB'($signed(held_cx_reg)) + sx;
        py = CB'(screen_height) - (CB'($signed(held_cy_reg)) + sy);

        case (cmd.mul_sel)
            mer_pkg::MUL_RX_RX:
            begin
                mul_a = MA'(rx_hold_reg);
                mul_b = MB'(rx_hold_reg);
            end
            mer_pkg::MUL_RY_RY:
            begin
                mul_a = MA'(cur_y_reg[R-1:0]);
                mul_b = MB'(cur_y_reg[R-1:0]);
            end
            mer_pkg::MUL_RXSQ_RY:
            begin
                mul_a = MA'(rx_sq_reg);
                mul_b = MB'(cur_y_reg[R-1:0]);
            end
            mer_pkg::MUL_RYSQ_T:
            begin
                mul_a = MA'(ry_sq_reg);
                mul_b = MB'(t_val);
            end
            mer_pkg::MUL_PROD_T:
            begin
                mul_a = prod_reg[MA-1:0];
                mul_b = MB'(t_val);
            end
            mer_pkg::MUL_YM1_YM1:
            begin
                mul_a = MA'(ym1_mag[YB-1:0]);
                mul_b = MB'(ym1_mag[YB-1:0]);
            end
            mer_pkg::MUL_RXSQ_PROD:
            begin
                mul_a = MA'(rx_sq_reg);
                mul_b = prod_reg[MB-1:0];
            end
            mer_pkg::MUL_RXSQ_RYSQ:
            begin
                mul_a = MA'(rx_sq_reg);
                mul_b = MB'(ry_sq_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        region_two_next = region_two_reg;
        active_next     = active_reg;
        rx_hold_next    = rx_hold_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        step_dx_next    = step_dx_reg;
        step_dy_next    = step_dy_reg;
        decision_next   = decision_reg;
        rx_sq_next      = rx_sq_reg;
        ry_sq_next      = ry_sq_reg;
        held_cx_next    = held_cx_reg;
        held_cy_next    = held_cy_reg;
        prod_next       = prod_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        diag_next       = diag_reg;
        done_next       = done_reg;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        done_res_next   = done_res_reg;
        last_next       = last_reg;

        if (cmd.mul_sel != mer_pkg::MUL_NONE)
            prod_next = mul_a * mul_b;

        case (cmd.wb_sel)
            mer_pkg::WB_RX_SQ:   rx_sq_next = prod_reg[SQ-1:0];
            mer_pkg::WB_RY_SQ:   ry_sq_next = prod_reg[SQ-1:0];
            mer_pkg::WB_START:
            begin
                step_dy_next  = {prod_reg[DB-2:0], 1'b0};
                decision_next = (DEC'(ry_sq_reg) << 2) - (prod_dec << 2) + DEC'(rx_sq_reg);
            end
            mer_pkg::WB_DEC_SET: decision_next = prod_dec;
            mer_pkg::WB_DEC_ADD: decision_next = decision_reg + (prod_dec << 2);
            mer_pkg::WB_DEC_SUB:
            begin
                decision_next   = decision_reg - (prod_dec << 2);
                region_two_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (cmd.load_start)
        begin
            rx_hold_next    = radius_x;
            cur_x_next      = '0;
            cur_y_next      = YB'(radius_y);
            step_dx_next    = '0;
            held_cx_next    = center_x;
            held_cy_next    = center_y;
            region_two_next = 1'b0;
            active_next     = 1'b1;
        end

        if (cmd.adv_move)
        begin
            x0_next   = cur_x_reg;
            y0_next   = cur_y_reg;
            diag_next = move_x && move_y;
            if (move_x)
            begin
                cur_x_next   = cur_x_reg + XB'(1);
                step_dx_next = step_dx_reg + (DB'(ry_sq_reg) << 1);
            end
            if (move_y)
            begin
                cur_y_next   = cur_y_reg - YB'(1);
                step_dy_next = step_dy_reg - (DB'(rx_sq_reg) << 1);
            end
        end

        if (cmd.adv_dec)
        begin
            decision_next = decision_reg + (term << 2);
            done_next     = cur_y_reg[YB-1];
            if (cur_y_reg[YB-1])
                active_next = 1'b0;
        end

        if (cmd.load_out)
        begin
            pixel_x_next  = px[PIX-1:0];
            pixel_y_next  = py[PIX-1:0];
            done_res_next = done_reg;
            last_next     = (cmd.quad == mer_pkg::QUAD_LAST);
        end

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_two_reg <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            region_two_reg <= region_two_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_hold_reg  <= rx_hold_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        step_dx_reg  <= step_dx_next;
        step_dy_reg  <= step_dy_next;
        decision_reg <= decision_next;
        rx_sq_reg    <= rx_sq_next;
        ry_sq_reg    <= ry_sq_next;
        held_cx_reg  <= held_cx_next;
        held_cy_reg  <= held_cy_next;
        prod_reg     <= prod_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        diag_reg     <= diag_next;
        done_reg     <= done_next;
        pixel_x_reg  <= pixel_x_next;
        pixel_y_reg  <= pixel_y_next;
        done_res_reg <= done_res_next;
        last_reg     <= last_next;
    end

    assign sts.active     = active_reg;
    assign sts.region_two = region_two_reg;
    assign sts.dx_ge_dy   = ($signed(step_dx_reg) >= $signed(step_dy_reg));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign done_res  = done_res_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[hw/rtl/midpoint_ellipse_rasterizer.sv]
// ---------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Top level: configuration registers, sequencer and datapath.
// ---------------------------------------------------------------------------
// A start request (operation 0) loads radii and center and returns nothing;
// setup runs on the shared multiplier, and region 2 setup follows when a zero
// radius sends the walk straight into region 2. A step request (operation 1)
// returns four points, (+x,+y) (+x,-y) (-x,+y) (-x,-y), with last on the
// fourth and done_res on every point of the final group; a step with no
// ellipse running is taken and dropped. A step runs a move state and a
// decision state, then one point per cycle through the single output register
// while the output is free, then a region check; the step that enters region 2
// adds a setup that builds the new decision value from five products on the one
// multiplier. Input is taken only between requests; the last point of a step
// may still wait on the output while the next request is taken.
// Configuration writes are always ready; write them only while idle.
`default_nettype none

module midpoint_ellipse_rasterizer
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_stall,
    input  wire logic                                      operation,
    input  wire logic        [mer_pkg::RADIUS_BITS-1:0]    radius_x,
    input  wire logic        [mer_pkg::RADIUS_BITS-1:0]    radius_y,
    input  wire logic signed [mer_pkg::COORD_BITS-1:0]     center_x,
    input  wire logic signed [mer_pkg::COORD_BITS-1:0]     center_y,
    output logic                                           out_valid,
    input  wire logic                                      out_stall,
    output logic signed      [mer_pkg::PIX_BITS-1:0]       pixel_x,
    output logic signed      [mer_pkg::PIX_BITS-1:0]       pixel_y,
    output logic                                           done_res,
    output logic                                           last,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic        [mer_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic        [mer_pkg::CFG_BITS-1:0]       cfg_data
);

    logic [mer_pkg::CFG_BITS-1:0] half_width_reg, half_width_next;
    logic [mer_pkg::CFG_BITS-1:0] height_reg,     height_next;

    mer_pkg::mer_cmd_t cmd;
    mer_pkg::mer_sts_t sts;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        half_width_next = half_width_reg;
        height_next     = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mer_pkg::REG_HALF_SCREEN_WIDTH: half_width_next = cfg_data;
                mer_pkg::REG_SCREEN_HEIGHT:     height_next     = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= mer_pkg::HALF_SCREEN_WIDTH_RESET;
            height_reg     <= mer_pkg::SCREEN_HEIGHT_RESET;
        end
        else
        begin
            half_width_reg <= half_width_next;
            height_reg     <= height_next;
        end
    end

    mer_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mer_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .radius_x          (radius_x),
        .radius_y          (radius_y),
        .center_x          (center_x),
        .center_y          (center_y),
        .half_screen_width (half_width_reg),
        .screen_height     (height_reg),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .pixel_x           (pixel_x),
        .pixel_y           (pixel_y),
        .done_res          (done_res),
        .last              (last),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

`default_nettype wire
